FILE: rtl/bgs_pkg.sv
package bgs_pkg;

    localparam int DATA_W    = 32;
    localparam int IDX_W     = 16;
    localparam int SIZE_W    = 9;
    localparam int INV_W     = 24;
    localparam int CELL_W    = 8;
    localparam int CFG_IDX_W = 3;
    localparam int COMP_N    = 3;
    localparam int CORNERS   = 4;
    localparam int CNT_W     = 3;

    // raw corner address (row * width + column + neighbors) stays below 2^17
    localparam int RAW_W = 17;

    localparam int IN_DATA_W  = 176;
    localparam int OUT_DATA_W = 96;

    localparam logic [SIZE_W-1:0] MIN_SIZE = 9'd2;
    localparam logic [SIZE_W-1:0] MAX_SIZE = 9'd256;

    localparam logic CMD_WRITE  = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INV_CELL    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_X    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ORIGIN_Z    = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MULX,
        ST_MULZ,
        ST_CLMPZ,
        ST_BASE,
        ST_FETCH,
        ST_LMUL,
        ST_LADD,
        ST_DONE
    } t_state;

    typedef enum logic [1:0] {
        LSTEP_ROW0,
        LSTEP_ROW1,
        LSTEP_COL
    } t_lstep;

endpackage

FILE: rtl/bilinear_grid_sampler_unit.sv
// Bilinear grid sampler. A write transaction (tuser = 0) stores one grid entry of three
// signed Q16.16 components in a single-port RAM; an index at or beyond GRID_ENTRIES is
// dropped. A sample transaction (tuser = 1) maps (x, z) into grid space with one shared
// 33x25 multiplier, clamps it, then reads the four corner entries through the one RAM
// port, one read per cycle behind a short modulo pipeline, and blends them with three
// component lanes in three multiply/add steps. The input is held off while a sample is
// in flight, and the next transaction is taken while the finished result waits in the
// output register. Reading an entry that was never written returns undefined data.
// Configuration writes are accepted every cycle and must only be issued while the block
// is idle.
module bilinear_grid_sampler_unit
    import bgs_pkg::*;
#(
    parameter int GRID_ENTRIES = 65536,
    parameter int FRAC_BITS    = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_addr,
    input  logic [DATA_W-1:0]     i_cfg_wdata,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // entry_index[15:0], write_a[47:16], write_b[79:48], write_c[111:80],
    // coord_x[143:112], coord_z[175:144]
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // command[0]
    input  logic [0:0]            s_axis_tuser,

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // sample_a[31:0], sample_b[63:32], sample_c[95:64]
    output logic [OUT_DATA_W-1:0] m_axis_tdata
);

    localparam int AW      = $clog2(GRID_ENTRIES);
    localparam int GW      = $clog2(GRID_ENTRIES + 1);
    localparam int CW      = ((GW > RAW_W) ? GW : RAW_W) + 1;
    localparam int RECIP_W = RAW_W + 1;
    localparam int RECIP   = (2 ** RAW_W) / GRID_ENTRIES;
    localparam int GCW     = FRAC_BITS + CELL_W;
    localparam int PW      = DATA_W + 1 + INV_W + 1;
    localparam int LW      = DATA_W + 1 + FRAC_BITS + 1;
    localparam int LO      = ((2 ** FRAC_BITS) + 50) / 100;
    localparam int ENT_W   = COMP_N * DATA_W;

    // configuration
    logic [SIZE_W-1:0]        r_gw;
    logic [SIZE_W-1:0]        r_gh;
    logic [INV_W-1:0]         r_inv;
    logic signed [DATA_W-1:0] r_ox;
    logic signed [DATA_W-1:0] r_oz;

    // control
    t_state                   r_state;
    t_state                   n_state;
    logic                     ld_out;
    logic                     s_acc;
    logic                     m_acc;
    logic                     cmd;
    logic                     ram_we;

    // coordinate path
    logic signed [DATA_W-1:0] r_cx;
    logic signed [DATA_W-1:0] r_cz;
    logic signed [DATA_W:0]   mul_d;
    logic signed [PW-1:0]     r_prod;
    logic signed [PW-1:0]     g_sh;
    logic [PW-1:0]            g_u;
    logic [SIZE_W-1:0]        nx;
    logic [SIZE_W-1:0]        ny;
    logic [SIZE_W-1:0]        clamp_n;
    logic [CELL_W-1:0]        n_m1;
    logic [GCW-1:0]           hi;
    logic [GCW-1:0]           g_clamped;
    logic [GCW-1:0]           r_gx;
    logic [GCW-1:0]           r_gz;
    logic [RAW_W-1:0]         r_base;

    // corner fetch
    logic [CNT_W-1:0]             r_issue;
    logic [CNT_W-1:0]             r_got;
    logic                         issue;
    logic [1:0]                   issue_tag;
    logic [RAW_W-1:0]             raw;
    logic                         r_m1_v;
    logic [1:0]                   r_m1_tag;
    logic [RAW_W-1:0]             r_m1_raw;
    logic [RAW_W+RECIP_W-1:0]     r_m1_p;
    logic [RECIP_W-1:0]           quot;
    logic [RECIP_W+GW-1:0]        qg_full;
    logic                         r_m2_v;
    logic [1:0]                   r_m2_tag;
    logic [RAW_W-1:0]             r_m2_raw;
    logic [RAW_W-1:0]             r_m2_qg;
    logic [RAW_W-1:0]             rem;
    logic [RAW_W-1:0]             rem_fix;
    logic [AW-1:0]                rd_addr;
    logic                         r_rd_v;
    logic [1:0]                   r_rd_tag;
    logic [AW-1:0]                ram_addr;
    logic [ENT_W-1:0]             ram_wdata;
    logic [ENT_W-1:0]             ram_rdata;

    // blend lanes
    t_lstep                   r_lstep;
    logic signed [DATA_W-1:0] r_cor  [CORNERS][COMP_N];
    logic signed [DATA_W-1:0] la     [COMP_N];
    logic signed [DATA_W-1:0] lb     [COMP_N];
    logic [FRAC_BITS-1:0]     lw;
    logic signed [DATA_W-1:0] r_la   [COMP_N];
    logic signed [LW-1:0]     r_lm   [COMP_N];
    logic signed [DATA_W-1:0] lsum   [COMP_N];
    logic signed [DATA_W-1:0] r_row0 [COMP_N];
    logic signed [DATA_W-1:0] r_row1 [COMP_N];
    logic signed [DATA_W-1:0] r_res  [COMP_N];

    logic                     r_out_valid;
    logic [OUT_DATA_W-1:0]    r_out_data;

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == ST_IDLE);
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign s_acc = s_axis_tvalid && s_axis_tready;
    assign m_acc = r_out_valid && m_axis_tready;
    assign cmd   = s_axis_tuser[0];

    // ---------------------------------------------------------------- config
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gw  <= MIN_SIZE;
            r_gh  <= MIN_SIZE;
            r_inv <= INV_W'(1 << FRAC_BITS);
            r_ox  <= '0;
            r_oz  <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_addr)
                CFG_GRID_WIDTH:  r_gw  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_GRID_HEIGHT: r_gh  <= i_cfg_wdata[SIZE_W-1:0];
                CFG_INV_CELL:    r_inv <= i_cfg_wdata[INV_W-1:0];
                CFG_ORIGIN_X:    r_ox  <= i_cfg_wdata;
                CFG_ORIGIN_Z:    r_oz  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        nx = r_gw;
        if (r_gw < MIN_SIZE) begin
            nx = MIN_SIZE;
        end else if (r_gw > MAX_SIZE) begin
            nx = MAX_SIZE;
        end
        ny = r_gh;
        if (r_gh < MIN_SIZE) begin
            ny = MIN_SIZE;
        end else if (r_gh > MAX_SIZE) begin
            ny = MAX_SIZE;
        end
    end

    // ---------------------------------------------------------------- sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        ld_out  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (s_acc && cmd == CMD_SAMPLE) begin
                    n_state = ST_MULX;
                end
            end
            ST_MULX:  n_state = ST_MULZ;
            ST_MULZ:  n_state = ST_CLMPZ;
            ST_CLMPZ: n_state = ST_BASE;
            ST_BASE:  n_state = ST_FETCH;
            ST_FETCH: begin
                if (r_got == CNT_W'(CORNERS)) begin
                    n_state = ST_LMUL;
                end
            end
            ST_LMUL: n_state = ST_LADD;
            ST_LADD: begin
                n_state = (r_lstep == LSTEP_COL) ? ST_DONE : ST_LMUL;
            end
            ST_DONE: begin
                if (!r_out_valid || m_acc) begin
                    ld_out  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // ---------------------------------------------------------------- grid coordinate
    assign mul_d = (r_state == ST_MULX)
                 ? ($signed({r_cx[DATA_W-1], r_cx}) - $signed({r_ox[DATA_W-1], r_ox}))
                 : ($signed({r_cz[DATA_W-1], r_cz}) - $signed({r_oz[DATA_W-1], r_oz}));

    assign clamp_n = (r_state == ST_MULZ) ? nx : ny;
    assign n_m1    = CELL_W'(clamp_n - SIZE_W'(1));
    assign hi      = {n_m1, {FRAC_BITS{1'b0}}} - GCW'(LO);
    assign g_sh    = r_prod >>> FRAC_BITS;
    assign g_u     = g_sh;

    // negative product lands on the low clamp like any small value
    always_comb begin
        if (r_prod[PW-1]) begin
            g_clamped = GCW'(LO);
        end else if (g_u > PW'(hi)) begin
            g_clamped = hi;
        end else if (g_u < PW'(LO)) begin
            g_clamped = GCW'(LO);
        end else begin
            g_clamped = g_u[GCW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_cx <= s_axis_tdata[143:112];
            r_cz <= s_axis_tdata[175:144];
        end
        if (r_state == ST_MULX || r_state == ST_MULZ) begin
            r_prod <= mul_d * $signed({1'b0, r_inv});
        end
        if (r_state == ST_MULZ) begin
            r_gx <= g_clamped;
        end
        if (r_state == ST_CLMPZ) begin
            r_gz <= g_clamped;
        end
        if (r_state == ST_BASE) begin
            r_base <= RAW_W'({{(RAW_W-CELL_W){1'b0}}, r_gz[GCW-1:FRAC_BITS]}
                             * {{(RAW_W-SIZE_W){1'b0}}, nx})
                    + RAW_W'(r_gx[GCW-1:FRAC_BITS]);
        end
    end

    // ---------------------------------------------------------------- corner fetch
    assign issue     = (r_state == ST_FETCH) && (r_issue != CNT_W'(CORNERS));
    assign issue_tag = r_issue[1:0];
    assign raw       = r_base + RAW_W'(issue_tag[0])
                     + (issue_tag[1] ? RAW_W'(nx) : RAW_W'(0));

    // wrap modulo the store depth: reciprocal estimate, then one correction
    assign quot    = r_m1_p[RAW_W+RECIP_W-1:RAW_W];
    assign qg_full = quot * GW'(GRID_ENTRIES);
    assign rem     = r_m2_raw - r_m2_qg;
    assign rem_fix = (CW'(rem) >= CW'(GRID_ENTRIES))
                   ? RAW_W'(CW'(rem) - CW'(GRID_ENTRIES)) : rem;
    assign rd_addr = AW'(rem_fix);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m1_v  <= 1'b0;
            r_m2_v  <= 1'b0;
            r_rd_v  <= 1'b0;
            r_issue <= '0;
            r_got   <= '0;
        end else begin
            r_m1_v <= issue;
            r_m2_v <= r_m1_v;
            r_rd_v <= r_m2_v;
            if (r_state == ST_BASE) begin
                r_issue <= '0;
                r_got   <= '0;
            end else begin
                if (issue) begin
                    r_issue <= r_issue + CNT_W'(1);
                end
                if (r_rd_v) begin
                    r_got <= r_got + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1_tag <= issue_tag;
        r_m1_raw <= raw;
        r_m1_p   <= raw * RECIP_W'(RECIP);
        r_m2_tag <= r_m1_tag;
        r_m2_raw <= r_m1_raw;
        r_m2_qg  <= qg_full[RAW_W-1:0];
        r_rd_tag <= r_m2_tag;
        if (r_rd_v) begin
            for (int k = 0; k < COMP_N; k++) begin
                r_cor[r_rd_tag][k] <= ram_rdata[k*DATA_W +: DATA_W];
            end
        end
    end

    assign ram_we    = s_acc && (cmd == CMD_WRITE)
                    && (CW'(s_axis_tdata[IDX_W-1:0]) < CW'(GRID_ENTRIES));
    assign ram_addr  = (r_state == ST_IDLE) ? AW'(s_axis_tdata[IDX_W-1:0]) : rd_addr;
    assign ram_wdata = s_axis_tdata[IDX_W +: ENT_W];

    bgs_ram #(
        .WIDTH (ENT_W),
        .DEPTH (GRID_ENTRIES)
    ) u_grid_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    // ---------------------------------------------------------------- blend
    // lerp(a, b, c) = a + floor((b - a) * c / one)
    always_comb begin
        lw = (r_lstep == LSTEP_COL) ? r_gz[FRAC_BITS-1:0] : r_gx[FRAC_BITS-1:0];
        for (int k = 0; k < COMP_N; k++) begin
            case (r_lstep)
                LSTEP_ROW0: begin
                    la[k] = r_cor[0][k];
                    lb[k] = r_cor[1][k];
                end
                LSTEP_ROW1: begin
                    la[k] = r_cor[2][k];
                    lb[k] = r_cor[3][k];
                end
                default: begin
                    la[k] = r_row0[k];
                    lb[k] = r_row1[k];
                end
            endcase
            lsum[k] = r_la[k] + DATA_W'(r_lm[k] >>> FRAC_BITS);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lstep <= LSTEP_ROW0;
        end else if (r_state == ST_BASE) begin
            r_lstep <= LSTEP_ROW0;
        end else if (r_state == ST_LADD) begin
            case (r_lstep)
                LSTEP_ROW0: r_lstep <= LSTEP_ROW1;
                LSTEP_ROW1: r_lstep <= LSTEP_COL;
                default:    r_lstep <= LSTEP_ROW0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < COMP_N; k++) begin
            if (r_state == ST_LMUL) begin
                r_la[k] <= la[k];
                r_lm[k] <= ($signed({lb[k][DATA_W-1], lb[k]})
                          - $signed({la[k][DATA_W-1], la[k]})) * $signed({1'b0, lw});
            end
            if (r_state == ST_LADD) begin
                case (r_lstep)
                    LSTEP_ROW0: r_row0[k] <= lsum[k];
                    LSTEP_ROW1: r_row1[k] <= lsum[k];
                    default:    r_res[k]  <= lsum[k];
                endcase
            end
        end
    end

    // ---------------------------------------------------------------- output
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (ld_out) begin
            r_out_valid <= 1'b1;
        end else if (m_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ld_out) begin
            r_out_data <= {r_res[2], r_res[1], r_res[0]};
        end
    end

    // ---------------------------------------------------------------- checks
    a_write_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == ST_IDLE))
        else $error("grid RAM written while a sample is in flight");

    a_read_in_fetch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_v |-> (r_state == ST_FETCH))
        else $error("corner read data returned outside the fetch phase");

    a_got_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FETCH) |-> (r_got <= r_issue))
        else $error("more corners returned than were issued");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DONE && n_state == ST_IDLE) |=> r_out_valid)
        else $error("finished sample did not reach the output register");

endmodule

FILE: rtl/bgs_ram.sv
module bgs_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 65536
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_addr] <= i_wdata;
        end
        o_rdata <= mem[i_addr];
    end

endmodule

FILE: sim/tb_bilinear_grid_sampler_unit.sv
`timescale 1ns / 100ps

module tb_bilinear_grid_sampler_unit;
    import bgs_pkg::*;

    localparam int     FRAC           = 16;
    localparam int     ENTRIES        = 65536;
    localparam longint ONE            = longint'(1) << FRAC;
    localparam longint S32_MAX        = 64'sd2147483647;
    localparam longint S32_MIN        = -64'sd2147483648;
    localparam int     CFG_REGS       = 5;
    localparam int     RX_HOLD_CYCLES = 400;
    localparam int     SETTLE_CYCLES  = 40;
    localparam int     PHASES         = 10;
    localparam int     PHASE_ITEMS    = 180;
    localparam int     MAX_REPORTS    = 10;

    typedef struct packed {
        logic              cmd;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] wa, wb, wc, x, z;
    } stim_t;

    typedef struct packed {
        stim_t                 it;
        logic                  check;
        logic [OUT_DATA_W-1:0] want;
    } row_t;

    typedef struct packed {
        logic [SIZE_W-1:0] w, h;
        logic [INV_W-1:0]  inv;
        logic [DATA_W-1:0] ox, oz;
    } cfg_set_t;

    typedef struct packed {
        logic [IDX_W-1:0] a00, a01, a10, a11;
        logic [FRAC-1:0]  wx, wz;
    } cell_t;

    // every corner holds the same entry, so any position returns it unchanged
    localparam logic [OUT_DATA_W-1:0] UNIFORM = {32'h00000000, 32'h80000000, 32'h7FFFFFFF};

    localparam int DIR_N = 19;
    localparam row_t DIRECTED [DIR_N] = '{
        '{'{CMD_WRITE,  16'h0000, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h0001, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h0002, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h0003, 32'h7FFFFFFF, 32'h80000000, 32'h00000000, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h00000000, 32'h00000000},
          1'b1, UNIFORM},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h7FFFFFFF},
          1'b1, UNIFORM},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h80000000, 32'h80000000},
          1'b1, UNIFORM},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h00008000, 32'h0000C000},
          1'b1, UNIFORM},
        '{'{CMD_WRITE,  16'h0000, 32'h00000000, 32'h00000000, 32'hFFFFFFFF, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h0001, 32'h00010000, 32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h0002, 32'hFFFF0000, 32'h80000000, 32'h7FFFFFFF, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h0003, 32'h00020000, 32'h12345678, 32'hFFFFFFFF, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h00008000, 32'h00008000},
          1'b0, 96'h0},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h00000000, 32'h00010000},
          1'b0, 96'h0},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h0000FFFF, 32'h00000001},
          1'b0, 96'h0},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h00004000, 32'hFFFFFFFF},
          1'b0, 96'h0},
        '{'{CMD_SAMPLE, 16'h0000, 32'h0, 32'h0, 32'h0, 32'h7FFFFFFF, 32'h80000000},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'hFFFF, 32'hAAAAAAAA, 32'h55555555, 32'hFFFFFFFF, 32'h0, 32'h0},
          1'b0, 96'h0},
        '{'{CMD_WRITE,  16'h8000, 32'h55555555, 32'hAAAAAAAA, 32'h00000001, 32'h0, 32'h0},
          1'b0, 96'h0}
    };

    // fixed settings first: extremes, out-of-range sizes and a zero reciprocal
    localparam int FIXED_N = 5;
    localparam cfg_set_t FIXED_SETS [FIXED_N] = '{
        '{9'd4,   9'd3,   24'h010000, 32'h00000000, 32'h00000000},
        '{9'd256, 9'd256, 24'h010000, 32'hFF800000, 32'hFF800000},
        '{9'd0,   9'd511, 24'h000000, 32'h12345678, 32'hFEDCBA98},
        '{9'd1,   9'd257, 24'hFFFFFF, 32'h7FFFFFFF, 32'h80000000},
        '{9'd17,  9'd9,   24'h000001, 32'h80000000, 32'h7FFFFFFF}
    };

    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_addr    = '0;
    logic [DATA_W-1:0]     i_cfg_wdata   = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
    logic [0:0]            s_axis_tuser  = '0;
    logic                  m_axis_tready = 1'b0;
    logic                  o_cfg_ready;
    logic                  s_axis_tready;
    logic                  m_axis_tvalid;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    logic [OUT_DATA_W-1:0] grid_shadow [ENTRIES];
    bit                    entry_written [ENTRIES];
    logic [SIZE_W-1:0]     cfg_w   = 9'd2;
    logic [SIZE_W-1:0]     cfg_h   = 9'd2;
    logic [INV_W-1:0]      cfg_inv = 24'h010000;
    logic [DATA_W-1:0]     cfg_ox  = '0;
    logic [DATA_W-1:0]     cfg_oz  = '0;

    logic [OUT_DATA_W-1:0] pending_samples [$];
    logic [OUT_DATA_W-1:0] head_sample;
    string                 field_names [COMP_N] = '{"sample_a", "sample_b", "sample_c"};
    int                    mismatch_count = 0;
    bit                    steady         = 1'b0;
    bit                    rx_hold_req    = 1'b0;

    always #4 i_clk = ~i_clk;

    bilinear_grid_sampler_unit i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_addr    (i_cfg_addr),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    function automatic int eff_size(logic [SIZE_W-1:0] n);
        if (n < MIN_SIZE) return int'(MIN_SIZE);
        if (n > MAX_SIZE) return int'(MAX_SIZE);
        return int'(n);
    endfunction

    // grid-space position along one axis, clamped into the interior of the grid
    function automatic longint axis_coord(logic [DATA_W-1:0] pos, logic [DATA_W-1:0] org,
                                          int n);
        longint lo, hi, prod, g;
        lo   = (ONE + 50) / 100;
        hi   = longint'(n - 1) * ONE - lo;
        prod = (longint'($signed(pos)) - longint'($signed(org))) * longint'(cfg_inv);
        if (prod < 0) return lo;
        g = prod >>> FRAC;
        if (g < lo) g = lo;
        if (g > hi) g = hi;
        return g;
    endfunction

    function automatic cell_t locate_cell(logic [DATA_W-1:0] x, logic [DATA_W-1:0] z);
        cell_t  c;
        int     nx, ny, base;
        longint gx, gz;
        nx    = eff_size(cfg_w);
        ny    = eff_size(cfg_h);
        gx    = axis_coord(x, cfg_ox, nx);
        gz    = axis_coord(z, cfg_oz, ny);
        base  = int'(gz >>> FRAC) * nx + int'(gx >>> FRAC);
        c.a00 = IDX_W'(base);
        c.a01 = IDX_W'(base + 1);
        c.a10 = IDX_W'(base + nx);
        c.a11 = IDX_W'(base + nx + 1);
        c.wx  = FRAC'(gx);
        c.wz  = FRAC'(gz);
        return c;
    endfunction

    function automatic longint grid_comp(logic [IDX_W-1:0] addr, int k);
        return longint'($signed(grid_shadow[addr][k*DATA_W +: DATA_W]));
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return (a * (ONE - w) + b * w) >>> FRAC;
    endfunction

    function automatic logic [OUT_DATA_W-1:0] predict_sample(logic [DATA_W-1:0] x,
                                                            logic [DATA_W-1:0] z);
        cell_t                 c;
        logic [OUT_DATA_W-1:0] res;
        longint                near_row, far_row, wx, wz;
        c  = locate_cell(x, z);
        wx = longint'(c.wx);
        wz = longint'(c.wz);
        for (int k = 0; k < COMP_N; k++) begin
            near_row = blend(grid_comp(c.a00, k), grid_comp(c.a01, k), wx);
            far_row  = blend(grid_comp(c.a10, k), grid_comp(c.a11, k), wx);
            res[k*DATA_W +: DATA_W] = DATA_W'(blend(near_row, far_row, wz));
        end
        return res;
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(9))
            0:       return 32'h7FFFFFFF;
            1:       return 32'h80000000;
            2:       return 32'h00000000;
            default: return $urandom;
        endcase
    endfunction

    function automatic stim_t random_stim(logic cmd);
        stim_t it;
        it.cmd = cmd;
        it.idx = IDX_W'($urandom);
        it.wa  = pick_value();
        it.wb  = pick_value();
        it.wc  = pick_value();
        it.x   = $urandom;
        it.z   = $urandom;
        return it;
    endfunction

    // position that lands near the grid, a little outside it now and then
    function automatic logic [DATA_W-1:0] aim_coord(logic [DATA_W-1:0] org, int n);
        longint spot, v;
        if (cfg_inv == 0) return $urandom;
        spot = longint'($urandom_range(0, (n + 1) * 65536)) - ONE;
        v    = longint'($signed(org)) + (spot <<< FRAC) / longint'(cfg_inv)
               + longint'($urandom_range(0, 4)) - 2;
        if (v > S32_MAX) v = S32_MAX;
        if (v < S32_MIN) v = S32_MIN;
        return DATA_W'(v);
    endfunction

    function automatic stim_t random_item();
        stim_t it;
        int    nx, ny;
        nx = eff_size(cfg_w);
        ny = eff_size(cfg_h);
        it = random_stim(($urandom_range(99) < 45) ? CMD_WRITE : CMD_SAMPLE);
        if (it.cmd == CMD_WRITE) begin
            if ($urandom_range(99) < 85) it.idx = IDX_W'($urandom_range(0, nx * ny - 1));
        end else if ($urandom_range(99) < 85) begin
            it.x = aim_coord(cfg_ox, nx);
            it.z = aim_coord(cfg_oz, ny);
        end
        return it;
    endfunction

    function automatic logic [SIZE_W-1:0] pick_size();
        case ($urandom_range(19))
            0:       return SIZE_W'($urandom);
            1, 2, 3: return SIZE_W'($urandom_range(17, 256));
            default: return SIZE_W'($urandom_range(2, 16));
        endcase
    endfunction

    function automatic cfg_set_t random_set();
        cfg_set_t s;
        s.w   = pick_size();
        s.h   = pick_size();
        s.inv = ($urandom_range(9) == 0) ? INV_W'($urandom)
                                         : INV_W'($urandom_range(1024, 24'h040000));
        s.ox  = 32'($signed(30'($urandom)));
        s.oz  = 32'($signed(30'($urandom)));
        return s;
    endfunction

    function automatic void note_mismatch(string what, logic [DATA_W-1:0] want,
                                          logic [DATA_W-1:0] got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display("mismatch on %s: expected %h, got %h", what, want, got);
    endfunction

    // one input transaction; called and returning at a falling edge
    task automatic send_raw(input stim_t it, input bit typed, input logic [OUT_DATA_W-1:0] val);
        while (!steady && $urandom_range(99) < 35) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.z, it.x, it.wc, it.wb, it.wa, it.idx};
        s_axis_tuser  <= it.cmd;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (it.cmd == CMD_WRITE) begin
            grid_shadow[it.idx]   = {it.wc, it.wb, it.wa};
            entry_written[it.idx] = 1'b1;
        end else begin
            pending_samples.push_back(typed ? val : predict_sample(it.x, it.z));
        end
        @(negedge i_clk);
    endtask

    // fill any corner that was never written before the sample reads it
    task automatic offer(input stim_t it, input bit typed, input logic [OUT_DATA_W-1:0] val);
        cell_t            c;
        stim_t            fill;
        logic [IDX_W-1:0] corners [CORNERS];
        if (it.cmd == CMD_SAMPLE) begin
            c       = locate_cell(it.x, it.z);
            corners = '{c.a00, c.a01, c.a10, c.a11};
            for (int k = 0; k < CORNERS; k++) begin
                if (!entry_written[corners[k]]) begin
                    fill     = random_stim(CMD_WRITE);
                    fill.idx = corners[k];
                    send_raw(fill, 1'b0, '0);
                end
            end
        end
        send_raw(it, typed, val);
    endtask

    task automatic program_grid(input cfg_set_t s);
        logic [CFG_IDX_W-1:0] regs [CFG_REGS];
        logic [DATA_W-1:0]    vals [CFG_REGS];
        regs = '{CFG_GRID_WIDTH, CFG_GRID_HEIGHT, CFG_INV_CELL, CFG_ORIGIN_X, CFG_ORIGIN_Z};
        // upper bits beyond the register width carry junk and must be dropped
        vals = '{{23'($urandom), s.w}, {23'($urandom), s.h}, {8'($urandom), s.inv}, s.ox, s.oz};
        for (int k = 0; k < CFG_REGS; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_addr  <= regs[k];
            i_cfg_wdata <= vals[k];
            @(posedge i_clk);
            while (!o_cfg_ready) @(posedge i_clk);
            case (regs[k])
                CFG_GRID_WIDTH:  cfg_w   = vals[k][SIZE_W-1:0];
                CFG_GRID_HEIGHT: cfg_h   = vals[k][SIZE_W-1:0];
                CFG_INV_CELL:    cfg_inv = vals[k][INV_W-1:0];
                CFG_ORIGIN_X:    cfg_ox  = vals[k];
                CFG_ORIGIN_Z:    cfg_oz  = vals[k];
                default: ;
            endcase
            @(negedge i_clk);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // hold the input until every sample is back, then let the pipeline settle
    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        while (pending_samples.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_samples.size() == 0) begin
                note_mismatch("sample with none pending", '0, m_axis_tdata[DATA_W-1:0]);
            end else begin
                head_sample = pending_samples.pop_front();
                for (int k = 0; k < COMP_N; k++) begin
                    if (m_axis_tdata[k*DATA_W +: DATA_W] !== head_sample[k*DATA_W +: DATA_W])
                        note_mismatch(field_names[k], head_sample[k*DATA_W +: DATA_W],
                                      m_axis_tdata[k*DATA_W +: DATA_W]);
                end
            end
        end
    end

    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold_left   = RX_HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= steady || ($urandom_range(99) >= 35);
            end
        end
    end

    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    initial begin
        cfg_set_t ph;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        for (int r = 0; r < DIR_N; r++)
            offer(DIRECTED[r].it, DIRECTED[r].check, DIRECTED[r].want);
        wait_idle();

        for (int p = 0; p < PHASES; p++) begin
            ph = (p < FIXED_N) ? FIXED_SETS[p] : random_set();
            program_grid(ph);
            // back up the output so the block stalls its input
            if (p == 1) rx_hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                steady = (p == 0 && n < 90);
                offer(random_item(), 1'b0, '0);
            end
            steady = 1'b0;
            wait_idle();
        end

        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sim.f
rtl/bgs_pkg.sv
rtl/bgs_ram.sv
rtl/bilinear_grid_sampler_unit.sv
sim/tb_bilinear_grid_sampler_unit.sv
